// ----- rtl/core/rgb_kernel_convolution_edge_normalized_assert.svh -----
// ----------------------------------------------------------------------------
// RGB kernel convolution assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RGB_KERNEL_CONVOLUTION_EDGE_NORMALIZED_ASSERT_SVH
`define RGB_KERNEL_CONVOLUTION_EDGE_NORMALIZED_ASSERT_SVH

// same-cycle implication
`define RKC_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define RKC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ----- rtl/core/rkc_pkg.sv -----
// ----------------------------------------------------------------------------
// rkc_pkg
// Shared types and constants of the RGB kernel convolution block.
// ----------------------------------------------------------------------------
package rkc_pkg;

	localparam int PIX_W      = 8;
	localparam int NUM_COEFFS = 25;
	localparam int COEF_VEC_W = 200;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int ROW_W      = 12;

	localparam logic ACT_PUSH  = 1'b0;
	localparam logic ACT_DRAIN = 1'b1;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WIDTH  = 3'd0,
		REG_HEIGHT = 3'd1,
		REG_RADIUS = 3'd2,
		REG_COEF0  = 3'd3,
		REG_COEF1  = 3'd4,
		REG_COEF2  = 3'd5,
		REG_COEF3  = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ACC,
		BK_FLUSH,
		BK_LOAD,
		BK_DIV,
		BK_OUT
	} bk_state_t;

	typedef struct packed {
		logic             last;
		logic             zero_div;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} res_t;

endpackage

// ----- rtl/core/rgb_kernel_convolution_edge_normalized.sv -----
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_edge_normalized
// Normalized RGB kernel convolution over a raster pixel stream, edge taps
// dropped, floored divide by the used absolute coefficient sum.
//
// channel   direction  handshake          word
// pixel     in         push / full        action, in_blue, in_green, in_red
// result    out        pop / empty        out_*, zero_divisor, last_of_frame
// config    in         cfg_valid/ready    cfg_index, cfg_data
//
// Front takes one word per cycle while full is low; a 4-entry job queue feeds the back end.
// Back end per output: window taps via the single line store read port, flush,
// load, bit-serial divide (skipped for a zero divisor) and one result push.
// full also rises after the frame's last job until the back end is empty.
// Async reset clears control only; the line store is not cleared.
// ----------------------------------------------------------------------------
`include "rgb_kernel_convolution_edge_normalized_assert.svh"

module rgb_kernel_convolution_edge_normalized #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_RADIUS = 2,
	parameter int COEFF_BITS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        action,
	input  logic [7:0]  in_blue,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_red,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_green,
	output logic [7:0]  out_red,
	output logic        zero_divisor,
	output logic        last_of_frame,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	localparam int DEPTH = MAX_WIDTH * (2 * MAX_RADIUS + 1);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int RDW   = $clog2(MAX_RADIUS + 1);
	localparam int JOB_W = rkc_pkg::ROW_W + COL_W + PTR_W + 1;
	localparam int RES_W = $bits(rkc_pkg::res_t);

	logic [11:0] width_q, height_q;
	logic [1:0]  radius_q;
	logic [63:0] coef0_q, coef1_q, coef2_q;
	logic [7:0]  coef3_q;

	logic [WW-1:0]                   w_eff;
	logic [rkc_pkg::ROW_W-1:0]       h_eff;
	logic [RDW-1:0]                  rad_eff;
	logic [rkc_pkg::COEF_VEC_W-1:0]  coef_vec;

	logic             job_push, job_pop, jobq_full, jobq_empty, back_idle;
	logic [JOB_W-1:0] job_data, job_head;
	logic             st_we;
	logic [PTR_W-1:0] st_addr;
	logic [23:0]      st_data;
	logic             res_push, res_full;
	rkc_pkg::res_t    res_data, res_head;
	logic [RES_W-1:0] res_raw;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd640;
			height_q <= 12'd480;
			radius_q <= 2'd1;
			coef0_q  <= '0;
			coef1_q  <= '0;
			coef2_q  <= '0;
			coef3_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				rkc_pkg::REG_WIDTH:  width_q  <= cfg_data[11:0];
				rkc_pkg::REG_HEIGHT: height_q <= cfg_data[11:0];
				rkc_pkg::REG_RADIUS: radius_q <= cfg_data[1:0];
				rkc_pkg::REG_COEF0:  coef0_q  <= cfg_data;
				rkc_pkg::REG_COEF1:  coef1_q  <= cfg_data;
				rkc_pkg::REG_COEF2:  coef2_q  <= cfg_data;
				rkc_pkg::REG_COEF3:  coef3_q  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = WW'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		h_eff    = (height_q == '0) ? 12'd1 : height_q;
		rad_eff  = (32'(radius_q) > MAX_RADIUS) ? RDW'(MAX_RADIUS) : RDW'(radius_q);
		coef_vec = {coef3_q, coef2_q, coef1_q, coef0_q};
	end

	rkc_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_RADIUS(MAX_RADIUS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.action    (action),
		.pix       ({in_red, in_green, in_blue}),
		.w_eff     (w_eff),
		.h_eff     (h_eff),
		.rad_eff   (rad_eff),
		.jobq_full (jobq_full),
		.jobq_empty(jobq_empty),
		.back_idle (back_idle),
		.full      (full),
		.job_push  (job_push),
		.job_data  (job_data),
		.st_we     (st_we),
		.st_addr   (st_addr),
		.st_data   (st_data)
	);

	rkc_fifo #(
		.WIDTH(JOB_W),
		.DEPTH(4)
	) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (job_push),
		.wr_data(job_data),
		.rd_en  (job_pop),
		.rd_data(job_head),
		.full   (jobq_full),
		.empty  (jobq_empty)
	);

	rkc_back #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_RADIUS(MAX_RADIUS),
		.COEFF_BITS(COEFF_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(~jobq_empty),
		.job_data (job_head),
		.job_pop  (job_pop),
		.st_we    (st_we),
		.st_addr  (st_addr),
		.st_data  (st_data),
		.w_eff    (w_eff),
		.h_eff    (h_eff),
		.rad_eff  (rad_eff),
		.coef_vec (coef_vec),
		.res_full (res_full),
		.res_push (res_push),
		.res_data (res_data),
		.back_idle(back_idle)
	);

	rkc_fifo #(
		.WIDTH(RES_W),
		.DEPTH(2)
	) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (res_push),
		.wr_data(res_data),
		.rd_en  (pop),
		.rd_data(res_raw),
		.full   (res_full),
		.empty  (empty)
	);

	assign res_head      = rkc_pkg::res_t'(res_raw);
	assign out_blue      = res_head.blue;
	assign out_green     = res_head.green;
	assign out_red       = res_head.red;
	assign zero_divisor  = res_head.zero_div;
	assign last_of_frame = res_head.last;

	`RKC_ASSERT_IMPL(a_jobq_no_overflow, job_push, !jobq_full, "job queue overflow")
	`RKC_ASSERT_IMPL(a_resq_no_overflow, res_push, !res_full, "result queue overflow")
	`RKC_ASSERT_NEXT(a_frame_end_holds, job_push && job_data[0], full, "frame end not held")
endmodule

// ----- rtl/core/rkc_fifo.sv -----
// ----------------------------------------------------------------------------
// rkc_fifo
// Small register queue with registered occupancy count.
// ----------------------------------------------------------------------------
module rkc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] data_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			data_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CW'(1);
			end
		end
	end
endmodule

// ----- rtl/core/rkc_front.sv -----
// ----------------------------------------------------------------------------
// rkc_front
// Accepts pixel and drain words, tracks frame position, writes the line
// store and issues one job per output pixel.
// ----------------------------------------------------------------------------
module rkc_front #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_RADIUS = 2
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	input  logic                                    action,
	input  logic [3*rkc_pkg::PIX_W-1:0]             pix,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]          w_eff,
	input  logic [rkc_pkg::ROW_W-1:0]               h_eff,
	input  logic [$clog2(MAX_RADIUS+1)-1:0]         rad_eff,
	input  logic                                    jobq_full,
	input  logic                                    jobq_empty,
	input  logic                                    back_idle,
	output logic                                    full,
	output logic                                    job_push,
	output logic [rkc_pkg::ROW_W + $clog2(MAX_WIDTH)
		+ $clog2(MAX_WIDTH*(2*MAX_RADIUS+1)):0]      job_data,
	output logic                                    st_we,
	output logic [$clog2(MAX_WIDTH*(2*MAX_RADIUS+1))-1:0] st_addr,
	output logic [3*rkc_pkg::PIX_W-1:0]             st_data
);
	localparam int DEPTH = MAX_WIDTH * (2 * MAX_RADIUS + 1);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = rkc_pkg::ROW_W;
	localparam int LAG_W = $clog2(MAX_RADIUS * MAX_WIDTH + MAX_RADIUS + 1);

	logic [RW-1:0]    in_row_q, out_row_q;
	logic [COL_W-1:0] in_col_q, out_col_q;
	logic [PTR_W-1:0] wr_ptr_q, out_ptr_q;
	logic [LAG_W-1:0] ahead_q;
	logic             done_q;
	logic             wait_q;

	logic             accept, is_push, is_drain, emit, emit_push;
	logic [WW-1:0]    in_col_inc, out_col_inc;
	logic [RW:0]      in_row_inc, out_row_inc;
	logic             in_col_wrap, out_col_wrap, done_new, last;
	logic [LAG_W-1:0] lag;

	assign full      = jobq_full | wait_q;
	assign accept    = push & ~full;
	assign is_push   = accept & (action == rkc_pkg::ACT_PUSH) & ~done_q;
	assign is_drain  = accept & (action == rkc_pkg::ACT_DRAIN) & done_q;

	assign in_col_inc  = WW'(in_col_q) + WW'(1);
	assign in_col_wrap = (in_col_inc >= w_eff);
	assign in_row_inc  = (RW+1)'(in_row_q) + (RW+1)'(1);
	assign done_new    = in_col_wrap & (in_row_inc >= (RW+1)'(h_eff));

	assign lag       = LAG_W'(rad_eff) * LAG_W'(w_eff) + LAG_W'(rad_eff);
	assign emit_push = is_push & (done_new | (ahead_q >= lag));
	assign emit      = emit_push | is_drain;

	assign out_col_inc  = WW'(out_col_q) + WW'(1);
	assign out_col_wrap = (out_col_inc >= w_eff);
	assign out_row_inc  = (RW+1)'(out_row_q) + (RW+1)'(1);
	assign last         = out_col_wrap & (out_row_inc >= (RW+1)'(h_eff));

	assign job_push = emit;
	assign job_data = {out_row_q, out_col_q, out_ptr_q, last};
	assign st_we    = is_push;
	assign st_addr  = wr_ptr_q;
	assign st_data  = pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q  <= '0;
			in_col_q  <= '0;
			out_row_q <= '0;
			out_col_q <= '0;
			wr_ptr_q  <= '0;
			out_ptr_q <= '0;
			ahead_q   <= '0;
			done_q    <= 1'b0;
			wait_q    <= 1'b0;
		end else begin
			if (wait_q && jobq_empty && back_idle) begin
				wait_q <= 1'b0;
			end
			if (is_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
				if (in_col_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_inc[RW-1:0];
				end else begin
					in_col_q <= in_col_inc[COL_W-1:0];
				end
				if (done_new) begin
					done_q <= 1'b1;
				end
				if (!emit_push) begin
					ahead_q <= ahead_q + LAG_W'(1);
				end
			end
			if (emit) begin
				out_ptr_q <= (out_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : out_ptr_q + PTR_W'(1);
				if (out_col_wrap) begin
					out_col_q <= '0;
					out_row_q <= out_row_inc[RW-1:0];
				end else begin
					out_col_q <= out_col_inc[COL_W-1:0];
				end
				if (last) begin
					in_row_q  <= '0;
					in_col_q  <= '0;
					out_row_q <= '0;
					out_col_q <= '0;
					wr_ptr_q  <= '0;
					out_ptr_q <= '0;
					ahead_q   <= '0;
					done_q    <= 1'b0;
					wait_q    <= 1'b1;
				end
			end
		end
	end
endmodule

// ----- rtl/core/rkc_back.sv -----
// ----------------------------------------------------------------------------
// rkc_back
// Holds the line store, walks the kernel window one tap per cycle,
// accumulates the three channels and runs a bit-serial floored divide.
// ----------------------------------------------------------------------------
module rkc_back #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_RADIUS = 2,
	parameter int COEFF_BITS = 8
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    job_valid,
	input  logic [rkc_pkg::ROW_W + $clog2(MAX_WIDTH)
		+ $clog2(MAX_WIDTH*(2*MAX_RADIUS+1)):0]      job_data,
	output logic                                    job_pop,
	input  logic                                    st_we,
	input  logic [$clog2(MAX_WIDTH*(2*MAX_RADIUS+1))-1:0] st_addr,
	input  logic [3*rkc_pkg::PIX_W-1:0]             st_data,
	input  logic [$clog2(MAX_WIDTH+1)-1:0]          w_eff,
	input  logic [rkc_pkg::ROW_W-1:0]               h_eff,
	input  logic [$clog2(MAX_RADIUS+1)-1:0]         rad_eff,
	input  logic [rkc_pkg::COEF_VEC_W-1:0]          coef_vec,
	input  logic                                    res_full,
	output logic                                    res_push,
	output rkc_pkg::res_t                           res_data,
	output logic                                    back_idle
);
	localparam int DEPTH = MAX_WIDTH * (2 * MAX_RADIUS + 1);
	localparam int PTR_W = $clog2(DEPTH);
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = rkc_pkg::ROW_W;
	localparam int RDW   = $clog2(MAX_RADIUS + 1);
	localparam int IW    = RDW + 1;
	localparam int KSIDE = 2 * MAX_RADIUS + 1;
	localparam int NPOS  = KSIDE * KSIDE;
	localparam int KW    = $clog2(NPOS);
	localparam int CW    = (COEFF_BITS < 8) ? COEFF_BITS : 8;
	localparam int PRD_W = 9 + CW;
	localparam int SUM_W = PRD_W + KW;
	localparam int DW    = CW + KW;
	localparam int AW    = PTR_W + 2;
	localparam int YW    = RW + 2;
	localparam int XW    = WW + 2;
	localparam int CNT_W = $clog2(SUM_W + 1);
	localparam int PW    = rkc_pkg::PIX_W;

	rkc_pkg::bk_state_t state_q, state_d;

	logic [3*PW-1:0]   line_mem_q [DEPTH];
	logic [3*PW-1:0]   rd_pix_s1;
	logic              acc_en_s1, inb_s1;
	logic signed [CW-1:0] coef_s1;

	logic [RW-1:0]     orow_q;
	logic [COL_W-1:0]  ocol_q;
	logic [PTR_W-1:0]  optr_q;
	logic              last_q;
	logic signed [IW-1:0] i_q, j_q;
	logic [KW-1:0]     k_q;
	logic signed [AW-1:0] rowoff_q;

	logic signed [SUM_W-1:0] sum_q [3];
	logic [DW-1:0]     used_q;
	logic [SUM_W-1:0]  dvd_q [3];
	logic [DW-1:0]     rem_q [3];
	logic [PW-1:0]     quo_q [3];
	logic              neg_q [3];
	logic [CNT_W-1:0]  cnt_q;
	logic              zd_q;

	logic signed [IW-1:0] rad_s;
	logic signed [YW-1:0] y;
	logic signed [XW-1:0] x;
	logic signed [AW-1:0] a_raw, a_fix, rw_prod;
	logic              inb, last_tap;
	logic [7:0]        cbyte;
	logic signed [CW-1:0] coef;
	logic signed [PRD_W-1:0] prod [3];
	logic signed [DW-1:0] cext;
	logic [DW-1:0]     cabs;
	logic [PW-1:0]     qfin [3];

	assign rad_s    = $signed(IW'(rad_eff));
	assign last_tap = (i_q == rad_s) && (j_q == rad_s);
	assign y        = $signed(YW'(orow_q)) + YW'(i_q);
	assign x        = $signed(XW'(ocol_q)) + XW'(j_q);
	assign inb      = (y >= 0) && (y < $signed(YW'(h_eff)))
		&& (x >= 0) && (x < $signed(XW'(w_eff)));
	assign a_raw    = $signed(AW'(optr_q)) + rowoff_q + AW'(j_q);
	assign rw_prod  = $signed(AW'(rad_eff) * AW'(w_eff));

	always_comb begin
		if (a_raw < 0) begin
			a_fix = a_raw + AW'(DEPTH);
		end else if (a_raw >= $signed(AW'(DEPTH))) begin
			a_fix = a_raw - AW'(DEPTH);
		end else begin
			a_fix = a_raw;
		end
	end

	assign cbyte = (32'(k_q) < rkc_pkg::NUM_COEFFS) ? coef_vec[8*k_q +: 8] : 8'd0;
	assign coef  = $signed(cbyte[CW-1:0]);
	assign cext  = DW'(coef_s1);
	assign cabs  = (cext < 0) ? DW'(-cext) : DW'(cext);

	always_comb begin
		for (int n = 0; n < 3; n++) begin
			prod[n] = $signed({1'b0, rd_pix_s1[PW*n +: PW]}) * coef_s1;
			if (!neg_q[n]) begin
				qfin[n] = quo_q[n];
			end else if (rem_q[n] != '0) begin
				qfin[n] = ~quo_q[n];
			end else begin
				qfin[n] = ~quo_q[n] + PW'(1);
			end
		end
	end

	// line store, one write and one read port
	always_ff @(posedge clk) begin
		if (st_we) begin
			line_mem_q[st_addr] <= st_data;
		end
		rd_pix_s1 <= line_mem_q[a_fix[PTR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rkc_pkg::BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		job_pop  = 1'b0;
		res_push = 1'b0;
		case (state_q)
			rkc_pkg::BK_IDLE: begin
				if (job_valid) begin
					job_pop = 1'b1;
					state_d = rkc_pkg::BK_ACC;
				end
			end
			rkc_pkg::BK_ACC: begin
				if (last_tap) begin
					state_d = rkc_pkg::BK_FLUSH;
				end
			end
			rkc_pkg::BK_FLUSH: state_d = rkc_pkg::BK_LOAD;
			rkc_pkg::BK_LOAD: begin
				state_d = (used_q == '0) ? rkc_pkg::BK_OUT : rkc_pkg::BK_DIV;
			end
			rkc_pkg::BK_DIV: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = rkc_pkg::BK_OUT;
				end
			end
			rkc_pkg::BK_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = rkc_pkg::BK_IDLE;
				end
			end
			default: state_d = rkc_pkg::BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_en_s1 <= 1'b0;
		end else begin
			acc_en_s1 <= (state_q == rkc_pkg::BK_ACC);
		end
	end

	always_ff @(posedge clk) begin
		inb_s1  <= inb;
		coef_s1 <= coef;
		case (state_q)
			rkc_pkg::BK_IDLE: begin
				{orow_q, ocol_q, optr_q, last_q} <= job_data;
				i_q      <= -rad_s;
				j_q      <= -rad_s;
				k_q      <= '0;
				rowoff_q <= -rw_prod;
				used_q   <= '0;
				for (int n = 0; n < 3; n++) begin
					sum_q[n] <= '0;
				end
			end
			rkc_pkg::BK_ACC: begin
				k_q <= k_q + KW'(1);
				if (j_q == rad_s) begin
					j_q      <= -rad_s;
					i_q      <= i_q + IW'(1);
					rowoff_q <= rowoff_q + $signed(AW'(w_eff));
				end else begin
					j_q <= j_q + IW'(1);
				end
			end
			rkc_pkg::BK_LOAD: begin
				zd_q  <= (used_q == '0);
				cnt_q <= CNT_W'(SUM_W);
				for (int n = 0; n < 3; n++) begin
					neg_q[n] <= sum_q[n][SUM_W-1];
					dvd_q[n] <= sum_q[n][SUM_W-1] ? SUM_W'(-sum_q[n]) : SUM_W'(sum_q[n]);
					rem_q[n] <= '0;
					quo_q[n] <= '0;
				end
			end
			rkc_pkg::BK_DIV: begin
				cnt_q <= cnt_q - CNT_W'(1);
				for (int n = 0; n < 3; n++) begin
					logic [DW:0] sh;
					sh = {rem_q[n], dvd_q[n][SUM_W-1]};
					if (sh >= {1'b0, used_q}) begin
						rem_q[n] <= DW'(sh - {1'b0, used_q});
						quo_q[n] <= {quo_q[n][PW-2:0], 1'b1};
					end else begin
						rem_q[n] <= sh[DW-1:0];
						quo_q[n] <= {quo_q[n][PW-2:0], 1'b0};
					end
					dvd_q[n] <= {dvd_q[n][SUM_W-2:0], 1'b0};
				end
			end
			default: ;
		endcase
		if (acc_en_s1 && inb_s1) begin
			used_q <= used_q + cabs;
			for (int n = 0; n < 3; n++) begin
				sum_q[n] <= sum_q[n] + SUM_W'(prod[n]);
			end
		end
	end

	assign back_idle         = (state_q == rkc_pkg::BK_IDLE);
	assign res_data.last     = last_q;
	assign res_data.zero_div = zd_q;
	assign res_data.blue     = zd_q ? '0 : qfin[0];
	assign res_data.green    = zd_q ? '0 : qfin[1];
	assign res_data.red      = zd_q ? '0 : qfin[2];
endmodule
